// File: hdl/aprt_pkg.sv
package aprt_pkg;

  // Width of every tick quantity
  localparam int unsigned TICK_BITS = 20;

  typedef logic [TICK_BITS-1:0] tick_t;

  // Configuration port
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_ADDR_BITS = 3;

  typedef enum logic {
    REG_LIMIT_FLOOR   = 1'b0,
    REG_LIMIT_CEILING = 1'b1
  } reg_idx_t;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_ACTIVATE  = 2'd1,
    OP_SET_LIMIT = 2'd2,
    OP_STOP_MON  = 2'd3
  } op_t;

  // Run status codes
  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_OBSERVING = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_IMMEDIATE = 2'd3
  } status_t;

  // Reset values
  localparam tick_t FLOOR_RESET   = tick_t'(1000);
  localparam tick_t CEILING_RESET = tick_t'(300000);
  localparam tick_t LIMIT_RESET   = tick_t'(30000);

endpackage

// File: hdl/adaptive_pump_run_timer_core.sv
// Adaptive pump run timer.
// Input channel: in_valid / in_stall carrying in_opcode (tick, activate,
// set limit, stop monitoring), in_amount and in_sensor_wet. Each beat gives
// exactly one result beat on out_valid / out_stall: pump drive, run status,
// the adaptive limit, the last run length and the finished / rejected flags.
// Latency: the result of a beat accepted at one edge is presented from the
// next cycle on, held in the output register.
// Throughput: one beat per cycle while the receiver does not stall; the whole
// state update is one pass of constant shifts, adds and compares between the
// state registers and the output register.
// When the receiver stalls, the result holds and in_stall rises until the
// result is taken; an unstalled output frees the input in the same cycle.
// Reset (rst_n low, synchronous): pump off, status idle, monitoring off,
// limit 30000 ticks, last run 0, floor 1000, ceiling 300000, no result.
// The APB port (psel..pready) writes floor at address 0, ceiling at address 4;
// the user must write it only while the block is idle; it is not enforced.
module adaptive_pump_run_timer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_opcode,
  input  aprt_pkg::tick_t                    in_amount,
  input  logic                               in_sensor_wet,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_pump_on,
  output logic [1:0]                         out_run_status,
  output aprt_pkg::tick_t                    out_current_limit,
  output aprt_pkg::tick_t                    out_last_run_ticks,
  output logic                               out_run_finished,
  output logic                               out_rejected,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [aprt_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [aprt_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [aprt_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import aprt_pkg::*;

  // Configuration registers
  tick_t floor_r, ceiling_r;
  logic  cfg_wr;
  reg_idx_t cfg_idx;

  // Run state
  status_t status_r, status_nxt;
  logic    mon_r, mon_nxt;
  logic    pumping_r, pumping_nxt;
  tick_t   elapsed_r, elapsed_nxt;
  tick_t   target_r, target_nxt;
  tick_t   limit_r, limit_nxt;
  tick_t   prev_r, prev_nxt;
  logic    finished_nxt, rejected_nxt;

  // Output register
  logic    out_valid_r;
  logic    pump_on_r, finished_r, rejected_r;
  status_t out_status_r;
  tick_t   out_limit_r, out_prev_r;

  logic in_accept, out_take;
  op_t  op;

  // Limit adaptation terms
  logic [TICK_BITS+3:0] prev_wide, prev_x15;
  tick_t                shrunk;
  logic [TICK_BITS:0]   grown;
  tick_t                adapted;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign prdata = (cfg_idx == REG_LIMIT_CEILING)
                  ? {{(CFG_DATA_BITS-TICK_BITS){1'b0}}, ceiling_r}
                  : {{(CFG_DATA_BITS-TICK_BITS){1'b0}}, floor_r};

  // Write the bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r   <= FLOOR_RESET;
      ceiling_r <= CEILING_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LIMIT_FLOOR:   floor_r   <= pwdata[TICK_BITS-1:0];
        REG_LIMIT_CEILING: ceiling_r <= pwdata[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the output register frees as it is taken
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign op        = op_t'(in_opcode);

  // Adapt the limit from the previous run: 15/16 after overflow, +1/32 after a full run
  assign prev_wide = {4'b0000, prev_r};
  assign prev_x15  = (prev_wide << 4) - prev_wide;
  assign shrunk    = prev_x15[TICK_BITS+3:4];
  assign grown     = {1'b0, limit_r} + {6'b000000, limit_r[TICK_BITS-1:5]};

  always_comb begin
    adapted = limit_r;
    if (status_r == ST_OVERFLOW) begin
      adapted = (shrunk < floor_r) ? floor_r : shrunk;
    end else if (status_r == ST_OBSERVING && prev_r >= limit_r) begin
      adapted = (grown > {1'b0, ceiling_r}) ? ceiling_r : grown[TICK_BITS-1:0];
    end
  end

  // Next state for one item
  always_comb begin
    status_nxt   = status_r;
    mon_nxt      = mon_r;
    pumping_nxt  = pumping_r;
    elapsed_nxt  = elapsed_r;
    target_nxt   = target_r;
    limit_nxt    = limit_r;
    prev_nxt     = prev_r;
    finished_nxt = 1'b0;
    rejected_nxt = 1'b0;

    if (op == OP_ACTIVATE && !pumping_r) begin
      // Start a run, or report an immediate overflow
      limit_nxt  = adapted;
      target_nxt = (in_amount < adapted) ? in_amount : adapted;
      if (in_sensor_wet) begin
        status_nxt = ST_IMMEDIATE;
        mon_nxt    = 1'b0;
      end else begin
        status_nxt  = ST_OBSERVING;
        mon_nxt     = 1'b1;
        elapsed_nxt = '0;
        if (target_nxt == '0) begin
          prev_nxt     = '0;
          finished_nxt = 1'b1;
        end else begin
          pumping_nxt = 1'b1;
        end
      end
    end else begin
      // Overflow check comes before the item's own action
      if (mon_r && in_sensor_wet) begin
        status_nxt = ST_OVERFLOW;
        mon_nxt    = 1'b0;
        if (pumping_r) begin
          pumping_nxt  = 1'b0;
          prev_nxt     = elapsed_r;
          finished_nxt = 1'b1;
        end
      end
      case (op)
        OP_TICK: begin
          if (pumping_nxt) begin
            elapsed_nxt = elapsed_r + tick_t'(1);
            if (elapsed_nxt >= target_r) begin
              pumping_nxt  = 1'b0;
              prev_nxt     = elapsed_nxt;
              finished_nxt = 1'b1;
            end
          end
        end
        OP_ACTIVATE: rejected_nxt = 1'b1;
        OP_SET_LIMIT: begin
          if (in_amount > ceiling_r) begin
            limit_nxt = ceiling_r;
          end else if (in_amount < floor_r) begin
            limit_nxt = floor_r;
          end else begin
            limit_nxt = in_amount;
          end
        end
        OP_STOP_MON: mon_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  // Hold the run state; advance it on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r  <= ST_IDLE;
      mon_r     <= 1'b0;
      pumping_r <= 1'b0;
      elapsed_r <= '0;
      target_r  <= '0;
      limit_r   <= LIMIT_RESET;
      prev_r    <= '0;
    end else if (in_accept) begin
      status_r  <= status_nxt;
      mon_r     <= mon_nxt;
      pumping_r <= pumping_nxt;
      elapsed_r <= elapsed_nxt;
      target_r  <= target_nxt;
      limit_r   <= limit_nxt;
      prev_r    <= prev_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pump_on_r    <= pumping_nxt;
      out_status_r <= status_nxt;
      out_limit_r  <= limit_nxt;
      out_prev_r   <= prev_nxt;
      finished_r   <= finished_nxt;
      rejected_r   <= rejected_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pump_on        = pump_on_r;
  assign out_run_status     = out_status_r;
  assign out_current_limit  = out_limit_r;
  assign out_last_run_ticks = out_prev_r;
  assign out_run_finished   = finished_r;
  assign out_rejected       = rejected_r;

  // A running pump has always some ticks left to go
  a_run_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    pumping_r |-> (elapsed_r < target_r))
    else $error("pump running with elapsed ticks at or past target");

  // Monitoring is on only while observing
  a_mon_observing: assert property (@(posedge clk) disable iff (!rst_n)
    mon_r |-> (status_r == ST_OBSERVING))
    else $error("monitoring on outside observing status");

  // Activate during a run is reported as rejected
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && op == OP_ACTIVATE && pumping_r) |=> (out_valid_r && rejected_r))
    else $error("activate while pumping not rejected");

  // A finished run leaves the pump off
  a_finish_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && finished_r) |-> !pump_on_r)
    else $error("run finished with pump still on");

endmodule

// File: verif/testbench.sv
module testbench;
  import aprt_pkg::*;

  // One result beat as the block presents it
  typedef struct packed {
    logic       pump_on;
    logic [1:0] run_status;
    tick_t      current_limit;
    tick_t      last_run_ticks;
    logic       run_finished;
    logic       rejected;
  } timer_report_t;

  // Tracks the timer state and holds the reports still owed by the block
  class run_timer_scoreboard;
    tick_t         floor_lim;
    tick_t         ceiling_lim;
    status_t       status;
    bit            monitoring;
    bit            pumping;
    tick_t         elapsed;
    tick_t         target;
    tick_t         limit_now;
    tick_t         prev_run;
    timer_report_t awaited_reports[$];
    int            errors;
    int            reports_seen;
    int            runs_ended;
    int            overflows;
    int            immediates;
    int            rejects;

    function new();
      floor_lim   = FLOOR_RESET;
      ceiling_lim = CEILING_RESET;
      status      = ST_IDLE;
      monitoring  = 1'b0;
      pumping     = 1'b0;
      elapsed     = '0;
      target      = '0;
      limit_now   = LIMIT_RESET;
      prev_run    = '0;
    endfunction

    function void write_reg(reg_idx_t idx, tick_t value);
      case (idx)
        REG_LIMIT_FLOOR:   floor_lim = value;
        REG_LIMIT_CEILING: ceiling_lim = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited_reports.size();
    endfunction

    function void end_run();
      pumping  = 1'b0;
      prev_run = elapsed;
    endfunction

    // Shrink after an overflow, grow after a run that hit the limit
    function void adapt_limit();
      logic [TICK_BITS+3:0] shrunk;
      logic [TICK_BITS:0]   grown;
      if (status == ST_OVERFLOW) begin
        shrunk    = ((TICK_BITS+4)'(prev_run) * (TICK_BITS+4)'(15)) >> 4;
        limit_now = (shrunk < (TICK_BITS+4)'(floor_lim)) ? floor_lim : tick_t'(shrunk);
      end else if (status == ST_OBSERVING && prev_run >= limit_now) begin
        grown     = (TICK_BITS+1)'(limit_now) + (TICK_BITS+1)'(limit_now >> 5);
        limit_now = (grown > (TICK_BITS+1)'(ceiling_lim)) ? ceiling_lim : tick_t'(grown);
      end
    endfunction

    // Advance the timer by one accepted input beat and queue its report
    function void predict_beat(op_t op, tick_t amount, bit wet);
      timer_report_t rep;
      bit            finished;
      bit            rej;
      finished = 1'b0;
      rej      = 1'b0;
      if (op == OP_ACTIVATE && !pumping) begin
        adapt_limit();
        target = (amount < limit_now) ? amount : limit_now;
        if (wet) begin
          status     = ST_IMMEDIATE;
          monitoring = 1'b0;
          immediates++;
        end else begin
          status     = ST_OBSERVING;
          monitoring = 1'b1;
          pumping    = 1'b1;
          elapsed    = '0;
          if (target == '0) begin
            end_run();
            finished = 1'b1;
          end
        end
      end else begin
        // Overflow check comes before the beat's own action
        if (monitoring && wet) begin
          status     = ST_OVERFLOW;
          monitoring = 1'b0;
          overflows++;
          if (pumping) begin
            end_run();
            finished = 1'b1;
          end
        end
        case (op)
          OP_TICK: begin
            if (pumping) begin
              elapsed = elapsed + tick_t'(1);
              if (elapsed >= target) begin
                end_run();
                finished = 1'b1;
              end
            end
          end
          OP_ACTIVATE: rej = 1'b1;
          OP_SET_LIMIT: begin
            if (amount > ceiling_lim) limit_now = ceiling_lim;
            else if (amount < floor_lim) limit_now = floor_lim;
            else limit_now = amount;
          end
          default: monitoring = 1'b0;
        endcase
      end
      runs_ended += int'(finished);
      rejects    += int'(rej);
      rep.pump_on        = pumping;
      rep.run_status     = status;
      rep.current_limit  = limit_now;
      rep.last_run_ticks = prev_run;
      rep.run_finished   = finished;
      rep.rejected       = rej;
      awaited_reports.push_back(rep);
    endfunction

    // Compare a result beat with the oldest awaited report
    function void check_result(timer_report_t got);
      timer_report_t want;
      if (awaited_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result beat with no report awaited: %p", got);
        return;
      end
      want = awaited_reports.pop_front();
      reports_seen++;
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: report %0d mismatch", reports_seen);
          $display("  pump_on  exp %0b got %0b | status exp %0d got %0d",
                   want.pump_on, got.pump_on, want.run_status, got.run_status);
          $display("  limit    exp %0d got %0d | last_run exp %0d got %0d",
                   want.current_limit, got.current_limit,
                   want.last_run_ticks, got.last_run_ticks);
          $display("  finished exp %0b got %0b | rejected exp %0b got %0b",
                   want.run_finished, got.run_finished, want.rejected, got.rejected);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  tick_t       in_amount;
  logic        in_sensor_wet;
  logic        out_valid;
  logic        out_stall;
  logic        out_pump_on;
  logic [1:0]  out_run_status;
  tick_t       out_current_limit;
  tick_t       out_last_run_ticks;
  logic        out_run_finished;
  logic        out_rejected;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic        pready;

  run_timer_scoreboard sb = new();
  bit steady;
  bit hold_done;
  int sent_count;
  int settings_used;

  adaptive_pump_run_timer_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_amount          (in_amount),
    .in_sensor_wet      (in_sensor_wet),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pump_on        (out_pump_on),
    .out_run_status     (out_run_status),
    .out_current_limit  (out_current_limit),
    .out_last_run_ticks (out_last_run_ticks),
    .out_run_finished   (out_run_finished),
    .out_rejected       (out_rejected),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop if the run hangs
  initial begin
    #(12 * 300000);
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, one long hold-off once the run is well under way
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent_count >= 200) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 30);
      end
    end
  end

  // Check every result beat taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_pump_on, out_run_status, out_current_limit,
                       out_last_run_ticks, out_run_finished, out_rejected});
  end

  // Offer one beat, hold it until accepted, then maybe idle
  task automatic send_beat(op_t op, tick_t amount, bit wet);
    int gap;
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_amount     <= amount;
    in_sensor_wet <= wet;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_beat(op, amount, wet);
    sent_count++;
    gap = (!steady && $urandom_range(99) < 30) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // APB write: setup then access cycle
  task automatic write_reg(reg_idx_t idx, tick_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Drain all outstanding results, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_bounds(tick_t lo, tick_t hi);
    drain();
    write_reg(REG_LIMIT_FLOOR, lo);
    write_reg(REG_LIMIT_CEILING, hi);
    settings_used++;
  endtask

  // Mostly short amounts so runs finish, some full-width values
  function automatic tick_t pick_amount();
    case ($urandom_range(9))
      0:       return tick_t'($urandom);
      1:       return '1;
      2:       return '0;
      3, 4:    return tick_t'($urandom_range(8));
      default: return tick_t'($urandom_range(80));
    endcase
  endfunction

  task automatic random_item();
    send_beat(op_t'($urandom_range(3)), pick_amount(), $urandom_range(99) < 20);
  endtask

  // Activate followed by a train of ticks with occasional disturbances
  task automatic run_sequence();
    int n;
    int pick;
    send_beat(OP_ACTIVATE, pick_amount(), $urandom_range(99) < 5);
    n = $urandom_range(70);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 3) send_beat(OP_TICK, tick_t'($urandom), 1'b1);
      else if (pick < 6) send_beat(OP_STOP_MON, tick_t'($urandom), 1'b0);
      else if (pick < 8) send_beat(OP_ACTIVATE, pick_amount(), 1'b0);
      else send_beat(OP_TICK, tick_t'($urandom), 1'b0);
    end
  endtask

  task automatic random_phase(int count);
    int stop_at;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      if ($urandom_range(99) < 65) run_sequence();
      else random_item();
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_TICK;
    in_amount     <= '0;
    in_sensor_wet <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    steady        = 1'b0;
    hold_done     = 1'b0;
    sent_count    = 0;
    settings_used = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset bounds, clamping, zero-length run, immediate overflow,
    // rejection and overflow during a run
    send_beat(OP_TICK, '1, 1'b0);
    send_beat(OP_STOP_MON, '0, 1'b1);
    send_beat(OP_SET_LIMIT, '0, 1'b0);
    send_beat(OP_SET_LIMIT, '1, 1'b0);
    send_beat(OP_SET_LIMIT, tick_t'(5000), 1'b0);
    send_beat(OP_ACTIVATE, '0, 1'b0);
    send_beat(OP_ACTIVATE, tick_t'(3), 1'b1);
    send_beat(OP_ACTIVATE, '1, 1'b0);
    send_beat(OP_ACTIVATE, tick_t'(7), 1'b0);
    send_beat(OP_TICK, '0, 1'b1);
    send_beat(OP_ACTIVATE, '0, 1'b0);

    // Directed: shrink after overflow, run to limit, grow, monitoring off
    set_bounds(tick_t'(2), tick_t'(40));
    send_beat(OP_SET_LIMIT, tick_t'(4), 1'b0);
    send_beat(OP_ACTIVATE, tick_t'(10), 1'b0);
    send_beat(OP_TICK, '0, 1'b0);
    send_beat(OP_TICK, '0, 1'b1);
    send_beat(OP_ACTIVATE, tick_t'(2), 1'b0);
    send_beat(OP_STOP_MON, '0, 1'b0);
    send_beat(OP_TICK, '0, 1'b1);
    send_beat(OP_TICK, '0, 1'b0);
    send_beat(OP_ACTIVATE, tick_t'(5), 1'b0);
    send_beat(OP_TICK, '0, 1'b1);

    // Random phases over several bound settings, extremes included
    set_bounds(tick_t'(1), tick_t'(64));
    steady = 1'b1;
    random_phase(65);
    steady = 1'b0;
    set_bounds('1, tick_t'(1));
    random_phase(65);
    set_bounds(tick_t'(16), '1);
    random_phase(65);
    set_bounds(tick_t'(1), tick_t'(1));
    random_phase(65);
    set_bounds(tick_t'(30), tick_t'(200));
    random_phase(65);
    drain();

    $display("Checked %0d result beats: %0d runs ended, %0d overflows,",
             sb.reports_seen, sb.runs_ended, sb.overflows);
    $display("%0d immediate, %0d rejected, %0d bound settings, one long hold-off, %0d mismatches",
             sb.immediates, sb.rejects, settings_used, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
